// ===== hw/rtl/knc_pkg.sv =====
// ----------------------------------------------------------------------------
// knc_pkg
// Shared constants, types and the half-period table of the keypad note
// controller.
// ----------------------------------------------------------------------------
package knc_pkg;

    localparam int NUM_BUTTONS = 16;
    localparam int NOTE_KEYS   = 13;
    localparam int NUM_OCTAVES = 6;

    // Control button positions in the scan word
    localparam int BTN_DOWN = 13;
    localparam int BTN_UP   = 14;
    localparam int BTN_WAVE = 15;

    localparam logic [7:0]  HOLD_COUNT_RESET  = 8'd10;
    localparam logic [2:0]  OCTAVE_MIN        = 3'd2;
    localparam logic [2:0]  OCTAVE_MAX        = 3'd7;
    localparam logic [2:0]  OCTAVE_RESET      = 3'd5;
    localparam logic [13:0] HALF_PERIOD_RESET = 14'd1911;

    typedef logic [NUM_BUTTONS-1:0] button_vec_t;

    typedef struct packed {
        logic        muted;
        logic [3:0]  note_index;
        logic [13:0] half_period_us;
        logic [2:0]  octave;
        logic [1:0]  waveform;
        logic [7:0]  led_byte;
        logic        led_send;
    } knc_result_t;

    // Truncated 1e6/f in microseconds, one row per note, columns octave 2..7
    localparam logic [13:0] HALF_PERIOD_TABLE [0:NOTE_KEYS-1][0:NUM_OCTAVES-1] = '{
        '{14'd15289, 14'd7644, 14'd3822, 14'd1911, 14'd955, 14'd477},
        '{14'd14430, 14'd7215, 14'd3607, 14'd1803, 14'd901, 14'd450},
        '{14'd13620, 14'd6810, 14'd3405, 14'd1702, 14'd851, 14'd425},
        '{14'd12856, 14'd6428, 14'd3214, 14'd1607, 14'd803, 14'd401},
        '{14'd12134, 14'd6067, 14'd3033, 14'd1516, 14'd758, 14'd379},
        '{14'd11453, 14'd5726, 14'd2863, 14'd1431, 14'd715, 14'd357},
        '{14'd10810, 14'd5405, 14'd2702, 14'd1351, 14'd675, 14'd337},
        '{14'd10204, 14'd5102, 14'd2551, 14'd1275, 14'd637, 14'd318},
        '{14'd9631,  14'd4815, 14'd2407, 14'd1203, 14'd601, 14'd300},
        '{14'd9090,  14'd4545, 14'd2272, 14'd1136, 14'd568, 14'd284},
        '{14'd8580,  14'd4290, 14'd2145, 14'd1072, 14'd536, 14'd268},
        '{14'd8099,  14'd4049, 14'd2024, 14'd1012, 14'd506, 14'd253},
        '{14'd7644,  14'd3822, 14'd1911, 14'd955,  14'd477, 14'd238}
    };

endpackage

// ===== hw/rtl/knc_scan_if.sv =====
// ----------------------------------------------------------------------------
// knc_scan_if
// Scan tick channel: one 16-bit button word per transfer.
// ----------------------------------------------------------------------------
interface knc_scan_if;
    logic        valid;
    logic        ready;
    logic [15:0] buttons_pressed;

    modport source (output valid, output buttons_pressed, input ready);
    modport sink   (input valid, input buttons_pressed, output ready);
endinterface

// ===== hw/rtl/knc_result_if.sv =====
// ----------------------------------------------------------------------------
// knc_result_if
// Result channel: note selection, tone half-period, octave, waveform and LED.
// ----------------------------------------------------------------------------
interface knc_result_if;
    logic        valid;
    logic        ready;
    logic        muted;
    logic [3:0]  note_index;
    logic [13:0] half_period_us;
    logic [2:0]  octave;
    logic [1:0]  waveform;
    logic [7:0]  led_byte;
    logic        led_send;

    modport source (
        output valid, output muted, output note_index, output half_period_us,
        output octave, output waveform, output led_byte, output led_send,
        input  ready
    );
    modport sink (
        input  valid, input muted, input note_index, input half_period_us,
        input  octave, input waveform, input led_byte, input led_send,
        output ready
    );
endinterface

// ===== hw/rtl/keyboard_note_controller_core.sv =====
// ----------------------------------------------------------------------------
// keyboard_note_controller_core
// Debounced 16-button keypad to note, octave, waveform and LED selection.
// The result of a scan tick is registered and valid in the cycle after its transfer.
// Throughput: one scan tick per cycle; the input stays ready while the output
// register is empty or being drained in the same cycle.
// Reset: counters and arm flags clear, octave 5, waveform 0, note 0, period 1911.
// ----------------------------------------------------------------------------
module keyboard_note_controller_core
    import knc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    knc_scan_if.sink      scan,
    knc_result_if.source  result,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata
);

    logic        [7:0] hold_count_reg;
    logic              out_valid_reg;
    logic              accept;
    button_vec_t       held;
    knc_result_t       merged;

    assign scan.ready = ~out_valid_reg | result.ready;
    assign accept     = scan.valid & scan.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count_reg <= HOLD_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            hold_count_reg <= cfg_wdata;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++)
    begin : g_lane
        knc_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .accept     (accept),
            .pressed    (scan.buttons_pressed[g]),
            .hold_count (hold_count_reg),
            .held       (held[g])
        );
    end

    knc_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .held   (held),
        .result (merged)
    );

    assign result.valid          = out_valid_reg;
    assign result.muted          = merged.muted;
    assign result.note_index     = merged.note_index;
    assign result.half_period_us = merged.half_period_us;
    assign result.octave         = merged.octave;
    assign result.waveform       = merged.waveform;
    assign result.led_byte       = merged.led_byte;
    assign result.led_send       = merged.led_send;

endmodule

// ===== hw/rtl/knc_lane.sv =====
// ----------------------------------------------------------------------------
// knc_lane
// Hold counter of one button: reloads while pressed, counts down after release.
// ----------------------------------------------------------------------------
module knc_lane
    import knc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       pressed,
    input  logic [7:0] hold_count,
    output logic       held
);

    logic [7:0] count_reg;
    logic [7:0] count_next;

    always_comb
    begin
        if (pressed)
        begin
            count_next = hold_count;
        end
        else if (count_reg != 8'd0)
        begin
            count_next = count_reg - 8'd1;
        end
        else
        begin
            count_next = 8'd0;
        end
    end

    // Held state as seen after this tick's update
    assign held = (count_next != 8'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 8'd0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/knc_merge.sv =====
// ----------------------------------------------------------------------------
// knc_merge
// Combines the lanes' held bits: priority note pick, half-period lookup and
// edge-armed octave and waveform controls. Registers the result.
// ----------------------------------------------------------------------------
module knc_merge
    import knc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  button_vec_t held,
    output knc_result_t result
);

    logic [2:0]  octave_reg;
    logic [2:0]  octave_next;
    logic [1:0]  wave_reg;
    logic [1:0]  wave_next;
    logic [3:0]  note_reg;
    logic [3:0]  note_next;
    logic [13:0] half_period_reg;
    logic [13:0] half_period_next;
    logic [2:0]  armed_reg;
    logic [2:0]  armed_next;
    logic        any_note;
    logic [3:0]  pick;
    logic [2:0]  octave_idx;
    logic        send;
    knc_result_t result_reg;
    knc_result_t result_next;

    always_comb
    begin
        any_note = 1'b0;
        pick     = 4'd0;
        for (int i = 0; i < NOTE_KEYS; i++)
        begin
            if (held[i])
            begin
                any_note = 1'b1;
                pick     = 4'(i);
            end
        end
    end

    // Lookup uses the octave from before this tick's change
    assign octave_idx = octave_reg - OCTAVE_MIN;

    always_comb
    begin
        note_next        = note_reg;
        half_period_next = half_period_reg;
        if (any_note)
        begin
            note_next        = pick;
            half_period_next = HALF_PERIOD_TABLE[pick][octave_idx];
        end
    end

    always_comb
    begin
        octave_next = octave_reg;
        wave_next   = wave_reg;
        send        = 1'b0;
        // Down acts before up when both fire
        if (held[BTN_DOWN] && armed_reg[0])
        begin
            send = 1'b1;
            if (octave_next > OCTAVE_MIN)
            begin
                octave_next = octave_next - 3'd1;
            end
        end
        if (held[BTN_UP] && armed_reg[1])
        begin
            send = 1'b1;
            if (octave_next < OCTAVE_MAX)
            begin
                octave_next = octave_next + 3'd1;
            end
        end
        if (held[BTN_WAVE] && armed_reg[2])
        begin
            wave_next = wave_reg + 2'd1;
        end
        // Re-arm only once the button is seen released
        armed_next = ~held[BTN_WAVE:BTN_DOWN];
    end

    always_comb
    begin
        result_next.muted          = ~any_note;
        result_next.note_index     = note_next;
        result_next.half_period_us = half_period_next;
        result_next.octave         = octave_next;
        result_next.waveform       = wave_next;
        result_next.led_byte       = 8'd1 << (octave_next - 3'd1);
        result_next.led_send       = send;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_reg      <= OCTAVE_RESET;
            wave_reg        <= 2'd0;
            note_reg        <= 4'd0;
            half_period_reg <= HALF_PERIOD_RESET;
            armed_reg       <= 3'b000;
        end
        else if (accept)
        begin
            octave_reg      <= octave_next;
            wave_reg        <= wave_next;
            note_reg        <= note_next;
            half_period_reg <= half_period_next;
            armed_reg       <= armed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
